// ----- sv/teb_pkg.sv -----
// Shared constants, key codes and types of the text entry buffer editor.
package teb_pkg;

  localparam int CAPACITY = 1024;
  localparam int AW       = $clog2(CAPACITY);
  localparam int POS_W    = 10;
  localparam int CHAR_W   = 8;

  localparam logic [CHAR_W-1:0] KEY_NONE          = 8'd0;
  localparam logic [CHAR_W-1:0] KEY_BACKSPACE     = 8'd8;
  localparam logic [CHAR_W-1:0] KEY_FIRST_SPECIAL = 8'd225;
  localparam logic [CHAR_W-1:0] KEY_UP            = 8'd226;
  localparam logic [CHAR_W-1:0] KEY_DOWN          = 8'd227;
  localparam logic [CHAR_W-1:0] KEY_LEFT          = 8'd228;
  localparam logic [CHAR_W-1:0] KEY_RIGHT         = 8'd229;
  localparam logic [CHAR_W-1:0] NEWLINE           = 8'd10;

  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PEEK,
    ST_SHR,
    ST_KEY,
    ST_SHL,
    ST_UP_LS,
    ST_UP_ST,
    ST_DN_LS,
    ST_DN_NL,
    ST_DN_END
  } state_t;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_READ,
    CMD_INS,
    CMD_DROP,
    CMD_DEL,
    CMD_LEFT,
    CMD_RIGHT,
    CMD_UP,
    CMD_DOWN
  } cmd_t;

endpackage

// ----- sv/teb_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
module teb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/text_entry_buffer_editor_top.sv -----
// Top level of the text entry buffer editor: command decode, edit sequencer, text RAM.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  input   | start / busy         | in_req_type, in_key_code, in_read_index
//  result  | out_valid (strobe)   | out_cursor_pos, out_text_length, out_changed,
//          |                      | out_dropped, out_read_char
//
// A beat is taken at a clock edge with start high and busy low; its result beat
// is strobed on out_valid for one cycle and cannot be held off by the receiver.
// Ignored codes, left and dropped inserts are answered from idle without the RAM;
// a read or a move right peeks one RAM word; an insert or a backspace shifts the
// tail between cursor and end one character at a time, and a line move walks the
// characters of the lines it crosses. The pace is set by the text RAM, which moves
// one character a cycle through its one read port and one write port.
// Reset (synchronous, rst_n low) clears cursor and length; no clearing pass runs:
// every RAM word that reaches a result or steers the sequencer lies below the
// length and was written since reset; a read past the end is masked to zero.
// Busy stays high from acceptance until the result strobe for beats that need the RAM.
module text_entry_buffer_editor_top
  import teb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_req_type,
  input  logic [CHAR_W-1:0] in_key_code,
  input  logic [POS_W-1:0]  in_read_index,
  output logic              out_valid,
  output logic [POS_W-1:0]  out_cursor_pos,
  output logic [POS_W-1:0]  out_text_length,
  output logic              out_changed,
  output logic              out_dropped,
  output logic [CHAR_W-1:0] out_read_char
);

  // Sequencer state
  state_t            state_r, state_nxt;
  logic [AW-1:0]     cur_r, cur_nxt;      // cursor
  logic [AW-1:0]     len_r, len_nxt;      // stored characters
  logic [AW-1:0]     a_r, a_nxt;          // address whose read data is on the RAM output
  logic              sv_r, sv_nxt;        // read data of a_r is live
  logic [AW-1:0]     col_r, col_nxt;      // column on the current line
  logic [AW-1:0]     nl_r, nl_nxt;        // newline ending a line of interest
  logic [CHAR_W-1:0] key_r, key_nxt;
  logic              rmode_r, rmode_nxt;  // peek serves a read request
  logic              rok_r, rok_nxt;      // read index below the length

  // Result registers
  logic              out_valid_r;
  logic [POS_W-1:0]  out_cur_r;
  logic [POS_W-1:0]  out_len_r;
  logic              out_chg_r;
  logic              out_drp_r;
  logic [CHAR_W-1:0] out_rch_r;

  // RAM port
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic              mem_re;
  logic [CHAR_W-1:0] mem_rdata;

  // Decode and loop conditions
  logic              in_fire;
  cmd_t              cmd;
  logic              rd_nl;
  logic              scan_fwd;
  logic              scan_done;
  logic [AW-1:0]     scan_res;
  logic              shr_last;
  logic              shl_last;

  // Finish of an item
  logic              fin;
  logic              fin_chg;
  logic              fin_drp;
  logic [CHAR_W-1:0] fin_rch;

  teb_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(a_nxt),
    .rdata(mem_rdata)
  );

  assign in_fire = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);

  // Classify the incoming beat against the current cursor and length
  always_comb begin
    cmd = CMD_NOP;
    priority if (in_req_type == REQ_READ) begin
      cmd = CMD_READ;
    end else if (in_key_code == KEY_NONE) begin
      cmd = CMD_NOP;
    end else if (in_key_code == KEY_BACKSPACE) begin
      cmd = (cur_r != '0) ? CMD_DEL : CMD_NOP;
    end else if (in_key_code < KEY_FIRST_SPECIAL) begin
      cmd = (len_r >= AW'(CAPACITY - 1)) ? CMD_DROP : CMD_INS;
    end else if (len_r == '0) begin
      cmd = CMD_NOP;
    end else if (in_key_code == KEY_LEFT) begin
      cmd = (cur_r != '0) ? CMD_LEFT : CMD_NOP;
    end else if (in_key_code == KEY_RIGHT) begin
      cmd = (cur_r < len_r) ? CMD_RIGHT : CMD_NOP;
    end else if (in_key_code == KEY_UP) begin
      cmd = CMD_UP;
    end else if (in_key_code == KEY_DOWN) begin
      cmd = CMD_DOWN;
    end else begin
      cmd = CMD_NOP;
    end
  end

  // Scan and shift loop conditions, evaluated on the word just read back
  always_comb begin
    rd_nl    = (mem_rdata == NEWLINE);
    scan_fwd = (state_r == ST_DN_NL) || (state_r == ST_DN_END);
    if (scan_fwd) begin
      // forward: first newline at or after the start, else the length
      scan_done = !sv_r || rd_nl || (({1'b0, a_r} + 1'b1) >= {1'b0, len_r});
      scan_res  = (!sv_r || rd_nl) ? a_r : len_r;
    end else begin
      // backward: position just after the previous newline, else 0
      scan_done = !sv_r || rd_nl || (a_r == '0);
      scan_res  = (sv_r && rd_nl) ? (a_r + AW'(1)) : '0;
    end
    shr_last = !sv_r || (a_r == cur_r);
    shl_last = !sv_r || (({1'b0, a_r} + 1'b1) >= {1'b0, len_r});
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            CMD_READ, CMD_RIGHT: state_nxt = ST_PEEK;
            CMD_INS:             state_nxt = ST_SHR;
            CMD_DEL:             state_nxt = ST_SHL;
            CMD_UP:              state_nxt = ST_UP_LS;
            CMD_DOWN:            state_nxt = ST_DN_LS;
            default:             state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PEEK: state_nxt = ST_IDLE;
      ST_SHR:  if (shr_last) state_nxt = ST_KEY;
      ST_KEY:  state_nxt = ST_IDLE;
      ST_SHL:  if (shl_last) state_nxt = ST_IDLE;
      ST_UP_LS: begin
        if (scan_done) state_nxt = (scan_res == '0) ? ST_IDLE : ST_UP_ST;
      end
      ST_UP_ST: if (scan_done) state_nxt = ST_IDLE;
      ST_DN_LS: if (scan_done) state_nxt = ST_DN_NL;
      ST_DN_NL: begin
        if (scan_done) state_nxt = (scan_res == len_r) ? ST_IDLE : ST_DN_END;
      end
      ST_DN_END: if (scan_done) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, RAM control and result
  always_comb begin
    logic          launch;
    logic          lfwd;
    logic [AW-1:0] lpos;
    logic [AW:0]   sum;

    launch    = 1'b0;
    lfwd      = 1'b0;
    lpos      = '0;
    sum       = '0;
    cur_nxt   = cur_r;
    len_nxt   = len_r;
    a_nxt     = a_r;
    sv_nxt    = sv_r;
    col_nxt   = col_r;
    nl_nxt    = nl_r;
    key_nxt   = key_r;
    rmode_nxt = rmode_r;
    rok_nxt   = rok_r;
    mem_we    = 1'b0;
    mem_waddr = a_r;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    fin       = 1'b0;
    fin_chg   = 1'b0;
    fin_drp   = 1'b0;
    fin_rch   = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          key_nxt = in_key_code;
          unique case (cmd)
            CMD_READ: begin
              // fetch the entry; mask it later if the index is past the end
              a_nxt     = AW'(in_read_index);
              mem_re    = 1'b1;
              rmode_nxt = 1'b1;
              rok_nxt   = ((AW + 1)'(in_read_index) < (AW + 1)'(len_r));
            end
            CMD_RIGHT: begin
              a_nxt     = cur_r;
              mem_re    = 1'b1;
              rmode_nxt = 1'b0;
            end
            CMD_INS: begin
              // walk the tail from its last character down to the cursor
              a_nxt  = len_r - AW'(1);
              sv_nxt = (len_r > cur_r);
              mem_re = sv_nxt;
            end
            CMD_DEL: begin
              // walk the tail from the cursor up to the end
              a_nxt  = cur_r;
              sv_nxt = (cur_r < len_r);
              mem_re = sv_nxt;
            end
            CMD_DROP: begin
              fin     = 1'b1;
              fin_drp = 1'b1;
            end
            CMD_LEFT: begin
              cur_nxt = cur_r - AW'(1);
              fin     = 1'b1;
              fin_chg = 1'b1;
            end
            CMD_UP, CMD_DOWN: begin
              launch = 1'b1;
              lpos   = cur_r;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      ST_PEEK: begin
        fin = 1'b1;
        if (rmode_r) begin
          fin_rch = rok_r ? mem_rdata : '0;
        end else if (!rd_nl) begin
          cur_nxt = cur_r + AW'(1);
          fin_chg = 1'b1;
        end
      end

      ST_SHR: begin
        if (sv_r) begin
          mem_we    = 1'b1;
          mem_waddr = a_r + AW'(1);
        end
        if (!shr_last) begin
          a_nxt  = a_r - AW'(1);
          mem_re = 1'b1;
        end
      end

      ST_KEY: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = key_r;
        cur_nxt   = cur_r + AW'(1);
        len_nxt   = len_r + AW'(1);
        fin       = 1'b1;
        fin_chg   = 1'b1;
      end

      ST_SHL: begin
        if (sv_r) begin
          mem_we    = 1'b1;
          mem_waddr = a_r - AW'(1);
        end
        if (shl_last) begin
          cur_nxt = cur_r - AW'(1);
          len_nxt = len_r - AW'(1);
          fin     = 1'b1;
          fin_chg = 1'b1;
        end else begin
          a_nxt  = a_r + AW'(1);
          mem_re = 1'b1;
        end
      end

      ST_UP_LS: begin
        if (scan_done) begin
          if (scan_res == '0) begin
            fin = 1'b1;                 // already on the first line
          end else begin
            col_nxt = cur_r - scan_res;
            nl_nxt  = scan_res - AW'(1);
            launch  = 1'b1;
            lpos    = scan_res - AW'(1);
          end
        end
      end

      ST_UP_ST: begin
        if (scan_done) begin
          sum     = {1'b0, scan_res} + {1'b0, col_r};
          cur_nxt = (sum < {1'b0, nl_r}) ? sum[AW-1:0] : nl_r;
          fin     = 1'b1;
          fin_chg = 1'b1;
        end
      end

      ST_DN_LS: begin
        if (scan_done) begin
          col_nxt = cur_r - scan_res;
          launch  = 1'b1;
          lfwd    = 1'b1;
          lpos    = cur_r;
        end
      end

      ST_DN_NL: begin
        if (scan_done) begin
          if (scan_res == len_r) begin
            fin = 1'b1;                 // already on the last line
          end else begin
            nl_nxt = scan_res;
            launch = 1'b1;
            lfwd   = 1'b1;
            lpos   = scan_res + AW'(1);
          end
        end
      end

      ST_DN_END: begin
        if (scan_done) begin
          sum     = {1'b0, nl_r} + {1'b0, col_r} + 1'b1;
          cur_nxt = (sum < {1'b0, scan_res}) ? sum[AW-1:0] : scan_res;
          fin     = 1'b1;
          fin_chg = 1'b1;
        end
      end

      default: begin
        fin = 1'b0;
      end
    endcase

    // Advance a running scan by one character
    if ((state_r == ST_UP_LS || state_r == ST_UP_ST || state_r == ST_DN_LS ||
         state_r == ST_DN_NL || state_r == ST_DN_END) && !scan_done) begin
      a_nxt  = scan_fwd ? (a_r + AW'(1)) : (a_r - AW'(1));
      mem_re = 1'b1;
    end

    // Start a new scan: forward reads from lpos, backward from lpos - 1
    if (launch) begin
      if (lfwd) begin
        a_nxt  = lpos;
        sv_nxt = (lpos < len_r);
      end else begin
        a_nxt  = lpos - AW'(1);
        sv_nxt = (lpos != '0);
      end
      mem_re = sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      len_r       <= '0;
      sv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      len_r       <= len_nxt;
      sv_r        <= sv_nxt;
      out_valid_r <= fin;
    end
  end

  // Working and result payload: no reset
  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    col_r   <= col_nxt;
    nl_r    <= nl_nxt;
    key_r   <= key_nxt;
    rmode_r <= rmode_nxt;
    rok_r   <= rok_nxt;
    if (fin) begin
      out_cur_r <= POS_W'(cur_nxt);
      out_len_r <= POS_W'(len_nxt);
      out_chg_r <= fin_chg;
      out_drp_r <= fin_drp;
      out_rch_r <= fin_rch;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cursor_pos  = out_cur_r;
  assign out_text_length = out_len_r;
  assign out_changed     = out_chg_r;
  assign out_dropped     = out_drp_r;
  assign out_read_char   = out_rch_r;

  // The cursor never passes the end of the text
  a_cur_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= len_r)
    else $error("cursor beyond text length");

  // The text never grows past one short of the capacity
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= AW'(CAPACITY - 1))
    else $error("text length beyond capacity");

  // Only the shift and key-write steps write the RAM
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_SHR || state_r == ST_KEY || state_r == ST_SHL))
    else $error("RAM write outside an edit step");

  // A result strobe always ends a busy item or answers a beat taken at once
  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(busy) || $past(start)))
    else $error("result strobe without an item");

endmodule

// ----- tb/text_entry_buffer_editor_top_test.sv -----
// Self-checking testbench for the text entry buffer editor: directed edits and random keystrokes.
`timescale 1ns / 100ps

module text_entry_buffer_editor_top_test
  import teb_pkg::*;
();

  // Cycles without any beat, in or out, before the run is declared hung. The slowest beat
  // walks the whole buffer.
  localparam int HANG_LIMIT  = 20000;
  // Quiet cycles after the last result, to catch any stray strobe.
  localparam int TAIL_CYCLES = 2100;
  localparam int RANDOM_KEYS = 248;

  // One keystroke or read request, with the chance (in percent) that the sender
  // idles in a given cycle before presenting it.
  typedef struct {
    logic              req;
    logic [CHAR_W-1:0] key;
    logic [POS_W-1:0]  idx;
    int                gap_pct;
  } key_beat_t;

  // What the editor reports after one beat.
  typedef struct {
    logic [POS_W-1:0]  cursor;
    logic [POS_W-1:0]  length;
    logic              changed;
    logic              dropped;
    logic [CHAR_W-1:0] rchar;
  } editor_view_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_req_type;
  logic [CHAR_W-1:0] in_key_code;
  logic [POS_W-1:0]  in_read_index;
  logic              out_valid;
  logic [POS_W-1:0]  out_cursor_pos;
  logic [POS_W-1:0]  out_text_length;
  logic              out_changed;
  logic              out_dropped;
  logic [CHAR_W-1:0] out_read_char;

  // Shadow copy of the editor: text, cursor and length.
  logic [CHAR_W-1:0] text_mem [CAPACITY];
  int                cur_pos;
  int                text_len;

  key_beat_t    keystrokes [$];   // beats still to be sent
  key_beat_t    on_wire;          // beat currently offered on the input ports
  editor_view_t awaited_views [$];
  int           mismatches;
  int           quiet_cycles;

  text_entry_buffer_editor_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_key_code     (in_key_code),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_cursor_pos  (out_cursor_pos),
    .out_text_length (out_text_length),
    .out_changed     (out_changed),
    .out_dropped     (out_dropped),
    .out_read_char   (out_read_char)
  );

  always #10 clk = ~clk;

  // Apply one beat to the shadow buffer and work out the editor's report.
  task automatic apply_beat(input key_beat_t b, output editor_view_t v);
    int col, p, nl, st, en, k;
    v.changed = 1'b0;
    v.dropped = 1'b0;
    v.rchar   = '0;
    if (b.req == REQ_READ) begin
      // Positions at or past the length read back as zero.
      if (b.idx < text_len) v.rchar = text_mem[b.idx];
    end else if (b.key == KEY_NONE) begin
      // Ignore the null code altogether.
    end else if (b.key == KEY_BACKSPACE) begin
      if (cur_pos > 0) begin
        for (k = cur_pos - 1; k + 1 < text_len; k++) text_mem[k] = text_mem[k + 1];
        text_mem[text_len - 1] = '0;
        cur_pos--;
        text_len--;
        v.changed = 1'b1;
      end
    end else if (b.key < KEY_FIRST_SPECIAL) begin
      // One slot is always kept spare; an insert into a full buffer is refused.
      if (text_len >= CAPACITY - 1) begin
        v.dropped = 1'b1;
      end else begin
        for (k = text_len; k > cur_pos; k--) text_mem[k] = text_mem[k - 1];
        text_mem[cur_pos] = b.key;
        cur_pos++;
        text_len++;
        v.changed = 1'b1;
      end
    end else if (text_len > 0) begin
      // Column of the cursor within its line, needed by the line moves.
      col = 0;
      p   = cur_pos;
      while (p > 0 && text_mem[p - 1] != NEWLINE) begin
        p--;
        col++;
      end
      case (b.key)
        KEY_LEFT: begin
          if (cur_pos > 0) begin
            cur_pos--;
            v.changed = 1'b1;
          end
        end
        KEY_RIGHT: begin
          // Stop at a newline or at the end of the text.
          if (cur_pos < text_len && text_mem[cur_pos] != NEWLINE) begin
            cur_pos++;
            v.changed = 1'b1;
          end
        end
        KEY_UP: begin
          // Nothing above the first line.
          if (p != 0) begin
            nl = p - 1;
            st = nl;
            while (st > 0 && text_mem[st - 1] != NEWLINE) st--;
            cur_pos   = (st + col < nl) ? st + col : nl;
            v.changed = 1'b1;
          end
        end
        KEY_DOWN: begin
          nl = cur_pos;
          while (nl < text_len && text_mem[nl] != NEWLINE) nl++;
          // Nothing below the last line.
          if (nl < text_len) begin
            en = nl + 1;
            while (en < text_len && text_mem[en] != NEWLINE) en++;
            cur_pos   = (nl + 1 + col < en) ? nl + 1 + col : en;
            v.changed = 1'b1;
          end
        end
        default: begin
          // Unused special codes leave everything as it is.
        end
      endcase
    end
    v.cursor = cur_pos[POS_W-1:0];
    v.length = text_len[POS_W-1:0];
  endtask

  // Key event with random junk in the unused read index.
  function automatic key_beat_t key_press(input logic [CHAR_W-1:0] k, input int gap);
    key_beat_t b;
    b.req     = REQ_KEY;
    b.key     = k;
    b.idx     = POS_W'($urandom);
    b.gap_pct = gap;
    return b;
  endfunction

  // Read request with random junk in the unused key code.
  function automatic key_beat_t read_at(input logic [POS_W-1:0] i, input int gap);
    key_beat_t b;
    b.req     = REQ_READ;
    b.key     = CHAR_W'($urandom);
    b.idx     = i;
    b.gap_pct = gap;
    return b;
  endfunction

  // Typing-like random traffic: inserts most often, with edits, arrows and reads mixed
  // in, plus some raw noise that reaches every code and both request kinds.
  function automatic key_beat_t random_keystroke(input int gap);
    key_beat_t b;
    int        r;
    r = $urandom_range(0, 99);
    b = key_press(CHAR_W'($urandom_range(32, 126)), gap);
    if (r < 30) begin
      // keep the printable character
    end else if (r < 36) b.key = NEWLINE;
    else if (r < 46) b.key = KEY_BACKSPACE;
    else if (r < 54) b.key = KEY_LEFT;
    else if (r < 62) b.key = KEY_RIGHT;
    else if (r < 70) b.key = KEY_UP;
    else if (r < 78) b.key = KEY_DOWN;
    else if (r < 90) begin
      b = read_at($urandom_range(0, 1) ? POS_W'($urandom_range(0, 63)) : POS_W'($urandom), gap);
    end else begin
      b.req = 1'($urandom_range(0, 1));
      b.key = CHAR_W'($urandom);
    end
    return b;
  endfunction

  // Driver: offer the next beat whenever the port is free; hold the payload while
  // the editor is busy; predict each beat at the edge that accepts it.
  always @(posedge clk) begin : drive_keystrokes
    editor_view_t view;
    if (rst_n) begin
      if (start && !busy) begin
        apply_beat(on_wire, view);
        awaited_views.push_back(view);
      end
      if (!start || !busy) begin
        if (keystrokes.size() > 0 && $urandom_range(0, 99) >= keystrokes[0].gap_pct) begin
          on_wire       = keystrokes.pop_front();
          start         <= 1'b1;
          in_req_type   <= on_wire.req;
          in_key_code   <= on_wire.key;
          in_read_index <= on_wire.idx;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed result must match the oldest outstanding prediction.
  always @(posedge clk) begin : check_views
    editor_view_t want;
    if (rst_n && out_valid) begin
      if (awaited_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing outstanding: cursor %0d length %0d",
                   out_cursor_pos, out_text_length);
      end else begin
        want = awaited_views.pop_front();
        if (out_cursor_pos !== want.cursor || out_text_length !== want.length ||
            out_changed !== want.changed || out_dropped !== want.dropped ||
            out_read_char !== want.rchar) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch: cursor %0d/%0d length %0d/%0d changed %0b/%0b ",
                   want.cursor, out_cursor_pos, want.length, out_text_length,
                   want.changed, out_changed);
            $display("dropped %0b/%0b char %02h/%02h (expected/actual)",
                     want.dropped, out_dropped, want.rchar, out_read_char);
          end
        end
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on either side.
  always @(posedge clk) begin : watch_progress
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : run_test
    int n, seg;
    int seg_gap [4] = '{0, 60, 16, 0};

    clk           = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_req_type   = REQ_KEY;
    in_key_code   = KEY_NONE;
    in_read_index = '0;
    mismatches    = 0;
    quiet_cycles  = 0;
    cur_pos       = 0;
    text_len      = 0;
    for (n = 0; n < CAPACITY; n++) text_mem[n] = '0;

    // Directed opening, back to back. Arrows, backspace and junk codes on an
    // empty buffer first; they must change nothing.
    keystrokes.push_back(key_press(KEY_LEFT, 0));
    keystrokes.push_back(key_press(KEY_RIGHT, 0));
    keystrokes.push_back(key_press(KEY_UP, 0));
    keystrokes.push_back(key_press(KEY_DOWN, 0));
    keystrokes.push_back(key_press(KEY_BACKSPACE, 0));
    keystrokes.push_back(key_press(KEY_NONE, 0));
    keystrokes.push_back(key_press(KEY_FIRST_SPECIAL, 0));
    keystrokes.push_back(key_press(8'hFF, 0));
    // Build three lines: {01 E0} {c} {x y}, using the lowest and highest
    // inserting codes.
    keystrokes.push_back(key_press(8'h01, 0));
    keystrokes.push_back(key_press(8'hE0, 0));
    keystrokes.push_back(key_press(NEWLINE, 0));
    keystrokes.push_back(key_press(8'h63, 0));
    keystrokes.push_back(key_press(NEWLINE, 0));
    keystrokes.push_back(key_press(8'h78, 0));
    keystrokes.push_back(key_press(8'h79, 0));
    // Down on the last line and right at the end do nothing.
    keystrokes.push_back(key_press(KEY_DOWN, 0));
    keystrokes.push_back(key_press(KEY_RIGHT, 0));
    // Up onto a shorter line clamps to its end; up again; up on the first line.
    keystrokes.push_back(key_press(KEY_UP, 0));
    keystrokes.push_back(key_press(KEY_UP, 0));
    keystrokes.push_back(key_press(KEY_UP, 0));
    // Left to the start and once more; right up to and into the newline.
    keystrokes.push_back(key_press(KEY_LEFT, 0));
    keystrokes.push_back(key_press(KEY_LEFT, 0));
    keystrokes.push_back(key_press(KEY_RIGHT, 0));
    keystrokes.push_back(key_press(KEY_RIGHT, 0));
    keystrokes.push_back(key_press(KEY_RIGHT, 0));
    // Down from column two onto the one-character line clamps.
    keystrokes.push_back(key_press(KEY_DOWN, 0));
    keystrokes.push_back(read_at(10'd2, 0));
    keystrokes.push_back(read_at(10'd7, 0));
    keystrokes.push_back(read_at(10'd1023, 0));
    keystrokes.push_back(key_press(KEY_BACKSPACE, 0));

    // Random typing in segments with different sender idling.
    for (seg = 0; seg < 4; seg++)
      for (n = 0; n < RANDOM_KEYS / 4; n++)
        keystrokes.push_back(random_keystroke(seg_gap[seg]));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (keystrokes.size() > 0 || start || awaited_views.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_views.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
